// File: design/decc_pkg.sv
`timescale 1ns / 1ps

package decc_pkg;

    // Code geometry: eight check rows over sixteen codeword positions.
    localparam int NUM_ROWS  = 8;
    localparam int NUM_COLS  = 16;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COL_IDX_W = 4;
    localparam int CFG_IDX_W = 4;

    // Request codes.
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // One check row per entry; bit 15 of a row is codeword position 0.
    typedef logic [NUM_ROWS-1:0][WORD_W-1:0] row_array_t;
    typedef logic [NUM_ROWS-1:0]             syndrome_t;
    typedef logic [COL_IDX_W-1:0]            col_idx_t;

    // Outcome of one transaction.
    typedef enum logic [1:0] {
        FIX_CLEAN = 2'd0,
        FIX_ONE   = 2'd1,
        FIX_TWO   = 2'd2,
        FIX_FAIL  = 2'd3
    } fix_status_t;

endpackage

// File: design/decc_core.sv
`timescale 1ns / 1ps

module decc_core
(
    input  decc_pkg::row_array_t          rows,
    input  logic                          req_type,
    input  logic [decc_pkg::BYTE_W-1:0]   data_byte,
    input  logic [decc_pkg::WORD_W-1:0]   received_word,
    output logic [decc_pkg::WORD_W-1:0]   code_word,
    output logic [decc_pkg::BYTE_W-1:0]   decoded_byte,
    output decc_pkg::fix_status_t         fix_status
);
    import decc_pkg::*;

    logic [BYTE_W-1:0]                 parity;
    syndrome_t                         syndrome;
    syndrome_t [NUM_COLS-1:0]          cols;
    logic [NUM_COLS-1:0]               single_hit;
    logic [NUM_COLS-1:0][NUM_COLS-1:0] pair_hit;
    logic [NUM_COLS-1:0]               row_hit;
    logic                              single_found;
    logic                              pair_found;
    col_idx_t                          single_idx;
    col_idx_t                          pair_i;
    col_idx_t                          pair_j;
    logic [NUM_COLS-1:0]               pair_row;
    logic [WORD_W-1:0]                 flip_mask;
    logic [WORD_W-1:0]                 fixed_word;
    fix_status_t                       dec_status;

    // Parity bits for encoding and the syndrome for decoding.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            parity[BYTE_W-1-r] = ^(rows[r][WORD_W-1:BYTE_W] & data_byte);
            syndrome[r]        = ^(rows[r] & received_word);
        end
    end

    // Columns of the check matrix; column c sits at bit 15-c of every row.
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                cols[c][r] = rows[r][WORD_W-1-c];
            end
        end
    end

    // Compare every column and every ordered pair (j above i) to the syndrome.
    // The first matching pair in scan order always has i below j.
    always_comb
    begin
        for (int i = 0; i < NUM_COLS; i++)
        begin
            single_hit[i] = (cols[i] == syndrome);
            for (int j = 0; j < NUM_COLS; j++)
            begin
                pair_hit[i][j] = (j > i) && ((cols[i] ^ cols[j]) == syndrome);
            end
            row_hit[i] = |pair_hit[i];
        end
    end

    // Priority pick: lowest single column, else lowest i and then lowest j.
    always_comb
    begin
        single_found = |single_hit;
        pair_found   = |row_hit;
        single_idx   = '0;
        pair_i       = '0;
        pair_j       = '0;
        for (int c = NUM_COLS-1; c >= 0; c--)
        begin
            if (single_hit[c])
            begin
                single_idx = COL_IDX_W'(c);
            end
            if (row_hit[c])
            begin
                pair_i = COL_IDX_W'(c);
            end
        end
        pair_row = pair_hit[pair_i];
        for (int c = NUM_COLS-1; c >= 0; c--)
        begin
            if (pair_row[c])
            begin
                pair_j = COL_IDX_W'(c);
            end
        end
    end

    // Build the correction mask and the outcome.
    always_comb
    begin
        flip_mask  = '0;
        dec_status = FIX_FAIL;
        if (syndrome == '0)
        begin
            dec_status = FIX_CLEAN;
        end
        else if (single_found)
        begin
            flip_mask  = {1'b1, {(WORD_W-1){1'b0}}} >> single_idx;
            dec_status = FIX_ONE;
        end
        else if (pair_found)
        begin
            flip_mask  = ({1'b1, {(WORD_W-1){1'b0}}} >> pair_i)
                       | ({1'b1, {(WORD_W-1){1'b0}}} >> pair_j);
            dec_status = FIX_TWO;
        end
        fixed_word = received_word ^ flip_mask;
    end

    // Select the result for the request type.
    always_comb
    begin
        if (req_type == REQ_DECODE)
        begin
            code_word    = fixed_word;
            decoded_byte = fixed_word[WORD_W-1:WORD_W-BYTE_W];
            fix_status   = dec_status;
        end
        else
        begin
            code_word    = {data_byte, parity};
            decoded_byte = '0;
            fix_status   = FIX_CLEAN;
        end
    end

endmodule

// File: design/double_error_correcting_codec_8_16.sv
`timescale 1ns / 1ps

// Double-error-correcting (16,8) codec. A transaction is taken on every clock
// edge where start is high; busy never rises, so one word per clock is
// sustained. Each result is marked by done for one cycle. A transaction is
// held in the input register, then passes through the syndrome, column match
// and correction logic into the result register that drives the outputs. The
// receiver cannot stall and must take every result as it comes. The eight
// check rows are written through the cfg port (cfg_ready is always high,
// indexes above 7 are ignored) and should only change while no transaction
// is in flight.
module double_error_correcting_codec_8_16
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            req_type,
    input  logic [decc_pkg::BYTE_W-1:0]     data_byte,
    input  logic [decc_pkg::WORD_W-1:0]     received_word,
    output logic                            done,
    output logic [decc_pkg::WORD_W-1:0]     code_word,
    output logic [decc_pkg::BYTE_W-1:0]     decoded_byte,
    output logic [1:0]                      fix_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [decc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [decc_pkg::WORD_W-1:0]     cfg_data
);
    import decc_pkg::*;

    row_array_t          rows_reg;
    logic                stage_valid_reg;
    logic                stage_req_reg;
    logic [BYTE_W-1:0]   stage_data_reg;
    logic [WORD_W-1:0]   stage_word_reg;
    logic                done_reg;
    logic [WORD_W-1:0]   code_word_reg;
    logic [WORD_W-1:0]   code_word_next;
    logic [BYTE_W-1:0]   decoded_byte_reg;
    logic [BYTE_W-1:0]   decoded_byte_next;
    fix_status_t         status_reg;
    fix_status_t         status_next;
    logic                cfg_write;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_ROWS));

    // Check-row registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (cfg_write)
        begin
            rows_reg[cfg_index[COL_IDX_W-2:0]] <= cfg_data;
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            stage_req_reg  <= req_type;
            stage_data_reg <= data_byte;
            stage_word_reg <= received_word;
        end
    end

    // Encode or correct in one pass.
    decc_core u_core
    (
        .rows          (rows_reg),
        .req_type      (stage_req_reg),
        .data_byte     (stage_data_reg),
        .received_word (stage_word_reg),
        .code_word     (code_word_next),
        .decoded_byte  (decoded_byte_next),
        .fix_status    (status_next)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            code_word_reg    <= code_word_next;
            decoded_byte_reg <= decoded_byte_next;
            status_reg       <= status_next;
        end
    end

    assign done         = done_reg;
    assign code_word    = code_word_reg;
    assign decoded_byte = decoded_byte_reg;
    assign fix_status   = status_reg;

    // Every accepted transaction enters the input stage and then produces a result.
    a_start_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> stage_valid_reg)
        else $error("accepted transaction did not enter the input stage");

    a_stage_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |=> done)
        else $error("staged transaction did not produce a result");

    // Encode results carry no decoded byte and a clean status.
    a_encode_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_req_reg == REQ_ENCODE) |=>
            (decoded_byte == '0 && fix_status == FIX_CLEAN))
        else $error("encode result has nonzero decode fields");

    // Decode results: the byte is the top of the corrected word.
    a_decode_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_req_reg == REQ_DECODE) |=>
            (decoded_byte == code_word[WORD_W-1:WORD_W-BYTE_W]))
        else $error("decoded byte does not match corrected word");

    // The number of flipped bits agrees with the reported status.
    a_decode_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_req_reg == REQ_DECODE) |=>
            ($countones(code_word ^ $past(stage_word_reg)) ==
                ((fix_status == FIX_FAIL) ? 0 : int'(fix_status))))
        else $error("flipped bit count disagrees with status");

endmodule
